FILE: rtl/ascii_word_tokenizer_core_macros.svh
// assertion helpers for the tokenizer checker
`ifndef ASCII_WORD_TOKENIZER_CORE_MACROS_SVH
`define ASCII_WORD_TOKENIZER_CORE_MACROS_SVH

// checked only outside reset
`define AWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define AWT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/awt_pkg.sv
package awt_pkg;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_APOS    = 8'h27;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic       text_end;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_upper(input logic [7:0] b);
        return b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    endfunction

    function automatic logic is_word_byte(input logic [7:0] b);
        return is_upper(b) || (b inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]})
            || (b inside {[CHAR_LOWER_A:CHAR_LOWER_Z]});
    endfunction

    function automatic logic is_joiner(input logic [7:0] b);
        return b inside {CHAR_APOS, CHAR_HYPHEN, CHAR_PERIOD, CHAR_COMMA};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return is_upper(b) ? b + CASE_OFFSET : b;
    endfunction

    function automatic result_t make_result(input logic [7:0] ch, input logic cv,
                                            input logic te, input logic xe);
        result_t r;
        r.out_char   = ch;
        r.char_valid = cv;
        r.token_end  = te;
        r.text_end   = xe;
        return r;
    endfunction

endpackage

FILE: rtl/awt_in_stage.sv
module awt_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

FILE: rtl/awt_token_unit.sv
module awt_token_unit import awt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] text_byte,
    output push_t      push
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic [7:0]       held_char_reg, held_char_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       conn_char_reg, conn_char_next;
    logic             conn_valid_reg, conn_valid_next;
    logic [LEN_W-1:0] token_len_reg, token_len_next;
    logic [1:0]       res_count;
    result_t          res_first, res_second;
    logic             word_byte;
    logic [7:0]       lower_byte;

    assign word_byte  = is_word_byte(text_byte);
    assign lower_byte = to_lower(text_byte);

    always_comb begin
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        conn_char_next  = conn_char_reg;
        conn_valid_next = conn_valid_reg;
        token_len_next  = token_len_reg;
        res_count       = 2'd0;
        res_first       = '0;
        res_second      = '0;

        // resolve the waiting connector with this byte as lookahead
        if (conn_valid_reg) begin
            conn_valid_next = 1'b0;
            conn_char_next  = CHAR_NUL;
            if (word_byte && token_len_reg != '0) begin
                if (token_len_reg < LEN_MAX) begin
                    if (held_valid_reg) begin
                        res_first = make_result(held_char_reg, 1'b1, 1'b0, 1'b0);
                        res_count = 2'd1;
                    end
                    held_char_next  = conn_char_reg;
                    held_valid_next = 1'b1;
                    token_len_next  = token_len_reg + LEN_ONE;
                end
            end else begin
                if (held_valid_reg) begin
                    res_first = make_result(held_char_reg, 1'b1, 1'b1, 1'b0);
                    res_count = 2'd1;
                end
                held_char_next  = CHAR_NUL;
                held_valid_next = 1'b0;
                token_len_next  = '0;
            end
        end

        if (text_byte == CHAR_NUL) begin
            if (held_valid_next) begin
                res_first  = make_result(held_char_next, 1'b1, 1'b1, 1'b0);
                res_second = make_result(CHAR_NUL, 1'b0, 1'b0, 1'b1);
                res_count  = 2'd2;
            end else if (res_count == 2'd0) begin
                res_first = make_result(CHAR_NUL, 1'b0, 1'b0, 1'b1);
                res_count = 2'd1;
            end else begin
                res_second = make_result(CHAR_NUL, 1'b0, 1'b0, 1'b1);
                res_count  = 2'd2;
            end
            held_char_next  = CHAR_NUL;
            held_valid_next = 1'b0;
            conn_char_next  = CHAR_NUL;
            conn_valid_next = 1'b0;
            token_len_next  = '0;
        end else if (word_byte) begin
            if (token_len_next < LEN_MAX) begin
                if (held_valid_next) begin
                    if (res_count == 2'd0) begin
                        res_first = make_result(held_char_next, 1'b1, 1'b0, 1'b0);
                    end else begin
                        res_second = make_result(held_char_next, 1'b1, 1'b0, 1'b0);
                    end
                    res_count = res_count + 2'd1;
                end
                held_char_next  = lower_byte;
                held_valid_next = 1'b1;
                token_len_next  = token_len_next + LEN_ONE;
            end
        end else if (is_joiner(text_byte) && token_len_next != '0) begin
            conn_char_next  = text_byte;
            conn_valid_next = 1'b1;
        end else begin
            if (held_valid_next) begin
                if (res_count == 2'd0) begin
                    res_first = make_result(held_char_next, 1'b1, 1'b1, 1'b0);
                end else begin
                    res_second = make_result(held_char_next, 1'b1, 1'b1, 1'b0);
                end
                res_count = res_count + 2'd1;
            end
            held_char_next  = CHAR_NUL;
            held_valid_next = 1'b0;
            token_len_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_char_reg  <= CHAR_NUL;
            held_valid_reg <= 1'b0;
            conn_char_reg  <= CHAR_NUL;
            conn_valid_reg <= 1'b0;
            token_len_reg  <= '0;
        end else if (fire) begin
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            conn_char_reg  <= conn_char_next;
            conn_valid_reg <= conn_valid_next;
            token_len_reg  <= token_len_next;
        end
    end

    assign push.count  = fire ? res_count : 2'd0;
    assign push.first  = res_first;
    assign push.second = res_second;

endmodule

FILE: rtl/awt_result_queue.sv
module awt_result_queue import awt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    result_t    slot0_reg, slot1_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid = count_reg != 2'd0;
    assign pop     = m_valid && m_ready;
    // a push only lands on a queue that is empty or whose last entry is popped in the same cycle
    assign room    = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);
    assign count_next = count_reg - {1'b0, pop} + push.count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            slot0_reg <= push.first;
            if (push.count == 2'd2) begin
                slot1_reg <= push.second;
            end
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign head = slot0_reg;

endmodule

FILE: rtl/ascii_word_tokenizer_core.sv
// a byte enters the input register and is resolved into the result queue when it has
// room; a word byte's own result appears once the following byte is resolved
// throughput: one byte per cycle unless m_ready stalls or a byte gives two results
// reset: synchronous active-low aresetn clears the word state, input register and queue
module ascii_word_tokenizer_core import awt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_char_valid,
    output logic       m_token_end,
    output logic       m_text_end
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       room;
    logic       fire;
    push_t      push;
    result_t    head;

    assign fire = byte_valid && room;

    awt_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .take        (fire),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    awt_token_unit #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_token_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .text_byte (byte_data),
        .push      (push)
    );

    awt_result_queue u_result_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_char   = head.out_char;
    assign m_char_valid = head.char_valid;
    assign m_token_end  = head.token_end;
    assign m_text_end   = head.text_end;

endmodule

FILE: rtl/awt_core_checker.sv
`include "ascii_word_tokenizer_core_macros.svh"

module awt_core_checker import awt_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_char_valid,
    input logic       m_token_end,
    input logic       m_text_end
);

    `AWT_ASSERT(a_beat_held, m_valid && !m_ready |=> m_valid, "result beat dropped while stalled")
    `AWT_ASSERT(a_empty_char, m_valid && !m_char_valid |-> m_out_char == CHAR_NUL && !m_token_end, "empty beat carries char data")
    `AWT_ASSERT(a_text_end_alone, m_valid && m_text_end |-> !m_char_valid, "text end beat carries a char")
    `AWT_ASSERT(a_lowercase, m_valid && m_char_valid |-> !is_upper(m_out_char), "upper-case char emitted")
    `AWT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind ascii_word_tokenizer_core awt_core_checker u_checker (.*);

FILE: verif/tokenizer_checker.sv
module tokenizer_checker import awt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_char_valid,
    input  logic       m_token_end,
    input  logic       m_text_end,
    output int         fail_count,
    output int         pending_results
);

    result_t    expected_beats[$];
    logic [7:0] held_char;
    logic       held_valid;
    logic [7:0] conn_char;
    logic       conn_valid;
    logic [7:0] kept_len;
    int         errors = 0;

    function automatic logic is_token_char(input logic [7:0] b);
        return (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9)
            || (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
            || (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
    endfunction

    function automatic logic is_connector(input logic [7:0] b);
        return b == CHAR_APOS || b == CHAR_HYPHEN || b == CHAR_PERIOD || b == CHAR_COMMA;
    endfunction

    task automatic push_beat(input logic [7:0] ch, input logic cv, input logic te,
                             input logic xe);
        result_t r;
        r.out_char   = ch;
        r.char_valid = cv;
        r.token_end  = te;
        r.text_end   = xe;
        expected_beats.push_back(r);
    endtask

    // the previous held byte goes out once a new one takes its place
    task automatic append_char(input logic [7:0] b);
        if (kept_len >= MAX_TOKEN_LEN) return;
        if (held_valid) push_beat(held_char, 1'b1, 1'b0, 1'b0);
        held_char  = b;
        held_valid = 1'b1;
        kept_len   = kept_len + 8'd1;
    endtask

    task automatic close_word();
        if (held_valid) push_beat(held_char, 1'b1, 1'b1, 1'b0);
        held_char  = '0;
        held_valid = 1'b0;
        kept_len   = '0;
    endtask

    task automatic predict_text_byte(input logic [7:0] b);
        logic       alnum;
        logic [7:0] c;
        alnum = is_token_char(b);
        c     = b;
        // a pending connector is settled by this byte
        if (conn_valid) begin
            conn_valid = 1'b0;
            if (alnum && kept_len > 0) append_char(conn_char);
            else close_word();
            conn_char = '0;
        end
        if (b == CHAR_NUL) begin
            close_word();
            push_beat(CHAR_NUL, 1'b0, 1'b0, 1'b1);
        end else if (alnum) begin
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) c = b + CASE_OFFSET;
            append_char(c);
        end else if (is_connector(b) && kept_len > 0) begin
            conn_char  = b;
            conn_valid = 1'b1;
        end else begin
            close_word();
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            held_char  = '0;
            held_valid = 1'b0;
            conn_char  = '0;
            conn_valid = 1'b0;
            kept_len   = '0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.out_char   = m_out_char;
                got.char_valid = m_char_valid;
                got.token_end  = m_token_end;
                got.text_end   = m_text_end;
                if (expected_beats.size() == 0) begin
                    flag_error($sformatf("unexpected beat: char=%02h cv=%0b te=%0b xe=%0b",
                        got.out_char, got.char_valid, got.token_end, got.text_end));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.out_char !== want.out_char || got.char_valid !== want.char_valid
                        || got.token_end !== want.token_end
                        || got.text_end !== want.text_end) begin
                        flag_error({
                            $sformatf("beat mismatch: expected char=%02h cv=%0b te=%0b xe=%0b",
                                want.out_char, want.char_valid, want.token_end,
                                want.text_end),
                            $sformatf(", got char=%02h cv=%0b te=%0b xe=%0b",
                                got.out_char, got.char_valid, got.token_end,
                                got.text_end)});
                    end
                end
            end
            if (s_valid && s_ready) predict_text_byte(s_text_byte);
        end
        fail_count      <= errors;
        pending_results <= expected_beats.size();
    end

endmodule

FILE: verif/testbench.sv
module testbench import awt_pkg::*;;

    localparam int TOKEN_MAX = 255;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_text_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_char_valid;
    logic       m_token_end;
    logic       m_text_end;
    int         fail_count;
    int         pending_results;
    int         sent_items = 0;
    bit         steady = 1'b0;

    always #5 aclk = ~aclk;

    ascii_word_tokenizer_core #(.MAX_TOKEN_LEN(TOKEN_MAX)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_text_byte(s_text_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_char(m_out_char),
        .m_char_valid(m_char_valid), .m_token_end(m_token_end), .m_text_end(m_text_end)
    );

    tokenizer_checker #(.MAX_TOKEN_LEN(TOKEN_MAX)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_text_byte(s_text_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_char(m_out_char),
        .m_char_valid(m_char_valid), .m_token_end(m_token_end), .m_text_end(m_text_end),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return CHAR_DIGIT_0 + 8'(r);
        if (r < 36) return CHAR_UPPER_A + 8'(r - 10);
        return CHAR_LOWER_A + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_connector();
        case ($urandom_range(0, 3))
            0: return CHAR_APOS;
            1: return CHAR_HYPHEN;
            2: return CHAR_PERIOD;
            default: return CHAR_COMMA;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_items++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    task automatic send_separator();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) send_byte(8'h20);
        else if (r < 6) send_byte(rand_connector());
        else if (r == 6) begin
            send_byte(rand_connector());
            send_byte(rand_connector());
        end else if (r == 7) send_byte(8'($urandom_range(128, 255)));
        else send_byte(8'($urandom_range(1, 255)));
    endtask

    task automatic send_random_text(input int text_no);
        int words;
        int len;
        int w;
        int i;
        steady = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 9) == 0) begin
            // raw noise
            len = $urandom_range(1, 30);
            repeat (len) send_byte(8'($urandom_range(1, 255)));
        end else begin
            words = $urandom_range(1, 12);
            for (w = 0; w < words; w++) begin
                // now and then a word near or past full length
                if (w == 0 && text_no % 25 == 12) len = $urandom_range(250, 300);
                else len = $urandom_range(1, 10);
                for (i = 0; i < len; i++) begin
                    send_byte(rand_word_char());
                    if (i < len - 1 && $urandom_range(0, 99) < 12) send_byte(rand_connector());
                end
                send_separator();
            end
        end
        send_byte(CHAR_NUL);
    endtask

    initial begin
        int run;
        int gap;
        int r;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            r   = $urandom_range(0, 9);
            run = (r < 2) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            r   = $urandom_range(0, 99);
            gap = (r < 70) ? $urandom_range(1, 2) : (r < 95) ? $urandom_range(3, 8)
                : $urandom_range(20, 50);
            m_ready <= 1'b1;
            repeat (run) @(negedge aclk);
            m_ready <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    end

    initial begin
        int text_no;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty text, case and digit limits, high bytes, connectors in every position
        send_byte(CHAR_NUL);
        send_str("AZaz09");
        send_byte(8'h80);
        send_str("Q-r.");
        send_byte(8'hFF);
        send_str("n,,m 'k");
        send_str("x'");
        send_byte(CHAR_NUL);

        text_no = 0;
        while (sent_items < 1950) begin
            if (text_no % 10 == 3) wait_drained();
            send_random_text(text_no);
            text_no++;
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
